[hdl/mwf_pkg.sv]
// ---------------------------------------------------------------------------
// mwf_pkg: shared types and constants of the median window filter
// Sizes of the line store and window, config codes, job and write structs.
// ---------------------------------------------------------------------------
`default_nettype none

package mwf_pkg;

  localparam int MaxWidth    = 1024;
  localparam int MaxHeight   = 4096;
  localparam int MaxRadius   = 2;
  localparam int MaxChannels = 4;
  localparam int Rows        = 2 * MaxRadius + 2;
  localparam int WinSide     = 2 * MaxRadius + 1;
  localparam int WinArea     = WinSide * WinSide;
  localparam int ColW        = $clog2(MaxWidth);
  localparam int RowW        = $clog2(MaxHeight);
  localparam int SlotW       = $clog2(Rows);
  localparam int AddrW       = SlotW + ColW;
  localparam int MemDepth    = Rows * MaxWidth;
  localparam int WinIdxW     = $clog2(WinArea);
  localparam int SideW       = $clog2(WinSide + 1);
  localparam int PixW        = 8 * MaxChannels;
  localparam int CfgW        = 13;
  localparam int QDepth      = 2;
  localparam int QPtrW       = $clog2(QDepth);
  localparam int QCntW       = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    CfgWidth    = 2'd0,
    CfgHeight   = 2'd1,
    CfgRadius   = 2'd2,
    CfgChannels = 2'd3
  } cfg_idx_e;

  // effective (saturated) configuration
  typedef struct packed {
    logic [10:0] w;
    logic [12:0] h;
    logic [1:0]  r;
    logic [2:0]  ch;
  } cfg_t;

  // one output to produce
  typedef struct packed {
    logic [ColW-1:0]  x;
    logic [RowW-1:0]  y;
    logic [SlotW-1:0] slot;
    logic             last;
  } job_t;

  // line store write
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [PixW-1:0]  data;
  } wr_t;

  // mirror about the edge pixel, then clamp
  function automatic logic [13:0] reflect(input logic signed [14:0] c, input logic [13:0] n);
    logic signed [15:0] v;
    logic signed [15:0] nn;
    nn = $signed({2'b00, n});
    v  = $signed({c[14], c});
    if (v < 0) v = -v;
    if (v >= nn) v = 16'sd2 * nn - v - 16'sd2;
    if (v < 0) v = 16'sd0;
    if (v >= nn) v = nn - 16'sd1;
    return v[13:0];
  endfunction

  function automatic logic [WinIdxW-1:0] win_last(input logic [1:0] r);
    case (r)
      2'd0:    return WinIdxW'(0);
      2'd1:    return WinIdxW'(8);
      default: return WinIdxW'(WinArea - 1);
    endcase
  endfunction

  function automatic logic [WinIdxW-1:0] win_mid(input logic [1:0] r);
    case (r)
      2'd0:    return WinIdxW'(0);
      2'd1:    return WinIdxW'(4);
      default: return WinIdxW'(WinArea / 2);
    endcase
  endfunction

endpackage

`default_nettype wire

[hdl/mwf_if.sv]
// ---------------------------------------------------------------------------
// mwf_if: stream channels of the median window filter
// Pixel input channel and median output channel, valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface mwf_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] chan0_in;
  logic [7:0] chan1_in;
  logic [7:0] chan2_in;
  logic [7:0] chan3_in;
  modport source(output valid, mode, chan0_in, chan1_in, chan2_in, chan3_in, input ready);
  modport sink(input valid, mode, chan0_in, chan1_in, chan2_in, chan3_in, output ready);
endinterface

interface mwf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  chan0_median;
  logic [7:0]  chan1_median;
  logic [7:0]  chan2_median;
  logic [7:0]  chan3_median;
  logic [9:0]  out_x;
  logic [11:0] out_y;
  logic        frame_end;
  modport source(output valid, chan0_median, chan1_median, chan2_median, chan3_median,
                 out_x, out_y, frame_end, input ready);
  modport sink(input valid, chan0_median, chan1_median, chan2_median, chan3_median,
               out_x, out_y, frame_end, output ready);
endinterface

`default_nettype wire

[hdl/mwf_front.sv]
// ---------------------------------------------------------------------------
// mwf_front: input side of the median window filter
// Accepts words, writes pixels to the line store, issues output jobs.
// ---------------------------------------------------------------------------
`default_nettype none

module mwf_front import mwf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic restart_i,
  input  wire logic busy_i,
  input  wire logic q_full_i,
  mwf_in_if.sink    in_ch,
  output logic      push_o,
  output job_t      job_o,
  output wr_t       wr_o
);

  logic [ColW-1:0]  in_col_q, in_col_d, emit_col_q, emit_col_d;
  logic [RowW-1:0]  in_row_q, in_row_d, emit_row_q, emit_row_d;
  logic [SlotW-1:0] in_slot_q, in_slot_d, emit_slot_q, emit_slot_d;
  logic             in_done_q, in_done_d;
  logic             frame_start, acc, emit, hit, last;

  // hold a new frame until the previous frame's jobs have read the store
  assign frame_start = (in_col_q == '0) && (in_row_q == '0) && !in_done_q;
  assign in_ch.ready = !q_full_i && !(frame_start && busy_i);
  assign acc         = in_ch.valid && in_ch.ready;

  assign hit  = (in_row_q > RowW'(cfg_i.r)) ||
                ((in_row_q == RowW'(cfg_i.r)) && (in_col_q >= ColW'(cfg_i.r)));
  assign last = (({1'b0, emit_row_q} + 13'd1) >= cfg_i.h) &&
                (({1'b0, emit_col_q} + 11'd1) >= cfg_i.w);

  always_comb begin
    in_col_d    = in_col_q;
    in_row_d    = in_row_q;
    in_slot_d   = in_slot_q;
    in_done_d   = in_done_q;
    emit_col_d  = emit_col_q;
    emit_row_d  = emit_row_q;
    emit_slot_d = emit_slot_q;
    emit        = 1'b0;
    wr_o.en     = 1'b0;
    wr_o.addr   = {in_slot_q, in_col_q};
    wr_o.data   = {in_ch.chan3_in, in_ch.chan2_in, in_ch.chan1_in, in_ch.chan0_in};
    if (acc) begin
      if (in_ch.mode) begin
        emit = in_done_q;
      end else if (!in_done_q) begin
        wr_o.en = 1'b1;
        emit    = hit;
        if (({1'b0, in_col_q} + 11'd1) >= cfg_i.w) begin
          in_col_d = '0;
          if (({1'b0, in_row_q} + 13'd1) >= cfg_i.h) begin
            in_row_d  = '0;
            in_slot_d = '0;
            in_done_d = 1'b1;
          end else begin
            in_row_d  = in_row_q + RowW'(1);
            in_slot_d = (in_slot_q == SlotW'(Rows - 1)) ? '0 : in_slot_q + SlotW'(1);
          end
        end else begin
          in_col_d = in_col_q + ColW'(1);
        end
      end
    end
    if (emit) begin
      if (last) begin
        in_col_d = '0; in_row_d = '0; in_slot_d = '0; in_done_d = 1'b0;
        emit_col_d = '0; emit_row_d = '0; emit_slot_d = '0;
      end else if (({1'b0, emit_col_q} + 11'd1) >= cfg_i.w) begin
        emit_col_d  = '0;
        emit_row_d  = emit_row_q + RowW'(1);
        emit_slot_d = (emit_slot_q == SlotW'(Rows - 1)) ? '0 : emit_slot_q + SlotW'(1);
      end else begin
        emit_col_d = emit_col_q + ColW'(1);
      end
    end
    if (restart_i) begin
      in_col_d = '0; in_row_d = '0; in_slot_d = '0; in_done_d = 1'b0;
      emit_col_d = '0; emit_row_d = '0; emit_slot_d = '0;
    end
  end

  assign push_o     = emit;
  assign job_o.x    = emit_col_q;
  assign job_o.y    = emit_row_q;
  assign job_o.slot = emit_slot_q;
  assign job_o.last = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0; in_row_q <= '0; in_slot_q <= '0; in_done_q <= 1'b0;
      emit_col_q <= '0; emit_row_q <= '0; emit_slot_q <= '0;
    end else begin
      in_col_q <= in_col_d; in_row_q <= in_row_d; in_slot_q <= in_slot_d;
      in_done_q <= in_done_d;
      emit_col_q <= emit_col_d; emit_row_q <= emit_row_d; emit_slot_q <= emit_slot_d;
    end
  end

endmodule

`default_nettype wire

[hdl/mwf_queue.sv]
// ---------------------------------------------------------------------------
// mwf_queue: job queue between front and back
// Two-entry fifo of output jobs.
// ---------------------------------------------------------------------------
`default_nettype none

module mwf_queue import mwf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  input  wire logic pop_i,
  output job_t      job_o,
  output logic      full_o,
  output logic      empty_o
);

  job_t             ent_q [QDepth];
  logic [QPtrW-1:0] wp_q, rp_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign job_o   = ent_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wp_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + QPtrW'(1);
      if (pop_i) rp_q <= rp_q + QPtrW'(1);
      cnt_q <= cnt_q + QCntW'(push_i) - QCntW'(pop_i);
    end
  end

endmodule

`default_nettype wire

[hdl/mwf_back.sv]
// ---------------------------------------------------------------------------
// mwf_back: window fetch and sort engine
// Owns the line store, gathers a reflected window, sorts it, emits medians.
// ---------------------------------------------------------------------------
`default_nettype none

module mwf_back import mwf_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire wr_t  wr_i,
  input  wire job_t job_i,
  input  wire logic job_valid_i,
  output logic      pop_o,
  output logic      busy_o,
  mwf_out_if.source out_ch
);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StFetch = 5'b00010,
    StLand  = 5'b00100,
    StSort  = 5'b01000,
    StDone  = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  job_t                job_q;
  logic [SideW-1:0]    dy_q, dy_d, dx_q, dx_d, side;
  logic [WinIdxW-1:0]  k_q, k_d, land_k_q, pass_q, pass_d;
  logic                land_v_q;
  logic [7:0]          val_q [MaxChannels][WinArea];
  logic [7:0]          val_d [MaxChannels][WinArea];
  logic [PixW-1:0]     mem_q [MemDepth];
  logic [PixW-1:0]     rd_data_q;
  logic [AddrW-1:0]    rd_addr;
  logic signed [14:0]  trow, tcol, off;
  logic [13:0]         rrow, rcol;
  logic signed [4:0]   s5;
  logic                out_valid_q, load;
  logic [7:0]          med_q [MaxChannels];
  logic [ColW-1:0]     ox_q;
  logic [RowW-1:0]     oy_q;
  logic                oend_q;

  assign side   = {cfg_i.r, 1'b1};
  assign busy_o = (state_q != StIdle);
  assign pop_o  = (state_q == StIdle) && job_valid_i;
  assign load   = (state_q == StDone) && (!out_valid_q || out_ch.ready);

  // reflected window address; rows land within r of the output row
  always_comb begin
    trow = $signed({3'b000, job_q.y}) + $signed({12'd0, dy_q}) - $signed({13'd0, cfg_i.r});
    tcol = $signed({5'd0, job_q.x}) + $signed({12'd0, dx_q}) - $signed({13'd0, cfg_i.r});
    rrow = reflect(trow, {1'b0, cfg_i.h});
    rcol = reflect(tcol, {3'b000, cfg_i.w});
    off  = $signed({1'b0, rrow}) - $signed({3'b000, job_q.y});
    s5   = $signed({2'b00, job_q.slot}) + $signed(off[4:0]);
    if (s5 < 0) s5 = s5 + 5'(Rows);
    else if (s5 >= 5'(Rows)) s5 = s5 - 5'(Rows);
    rd_addr = {s5[SlotW-1:0], rcol[ColW-1:0]};
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem_q[wr_i.addr] <= wr_i.data;
    rd_data_q <= mem_q[rd_addr];
  end

  always_comb begin
    state_d = state_q;
    dy_d    = dy_q;
    dx_d    = dx_q;
    k_d     = k_q;
    pass_d  = pass_q;
    val_d   = val_q;
    if (land_v_q) begin
      for (int c = 0; c < MaxChannels; c++) val_d[c][land_k_q] = rd_data_q[8*c +: 8];
    end
    case (state_q)
      StIdle: begin
        if (job_valid_i) begin
          state_d = StFetch;
          dy_d = '0; dx_d = '0; k_d = '0; pass_d = '0;
          // padding sorts to the top and never moves
          for (int c = 0; c < MaxChannels; c++)
            for (int i = 0; i < WinArea; i++) val_d[c][i] = 8'hFF;
        end
      end
      StFetch: begin
        k_d = k_q + WinIdxW'(1);
        if (dx_q == side - SideW'(1)) begin
          dx_d = '0;
          dy_d = dy_q + SideW'(1);
        end else begin
          dx_d = dx_q + SideW'(1);
        end
        if (k_q == win_last(cfg_i.r)) state_d = StLand;
      end
      StLand: state_d = StSort;
      StSort: begin
        // one odd-even transposition pass per cycle
        for (int c = 0; c < MaxChannels; c++)
          for (int i = 0; i < WinArea - 1; i++)
            if ((i % 2) == int'(pass_q[0]) && val_q[c][i] > val_q[c][i+1]) begin
              val_d[c][i]   = val_q[c][i+1];
              val_d[c][i+1] = val_q[c][i];
            end
        pass_d = pass_q + WinIdxW'(1);
        if (pass_q == win_last(cfg_i.r)) state_d = StDone;
      end
      StDone: if (load) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      land_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      land_v_q <= (state_q == StFetch);
      if (load) out_valid_q <= 1'b1;
      else if (out_ch.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= job_i;
    dy_q     <= dy_d;
    dx_q     <= dx_d;
    k_q      <= k_d;
    pass_q   <= pass_d;
    land_k_q <= k_q;
    val_q    <= val_d;
    if (load) begin
      for (int c = 0; c < MaxChannels; c++)
        med_q[c] <= (3'(c) < cfg_i.ch) ? val_q[c][win_mid(cfg_i.r)] : 8'd0;
      ox_q   <= job_q.x;
      oy_q   <= job_q.y;
      oend_q <= job_q.last;
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.chan0_median = med_q[0];
  assign out_ch.chan1_median = med_q[1];
  assign out_ch.chan2_median = med_q[2];
  assign out_ch.chan3_median = med_q[3];
  assign out_ch.out_x        = ox_q;
  assign out_ch.out_y        = oy_q;
  assign out_ch.frame_end    = oend_q;

endmodule

`default_nettype wire

[hdl/median_window_filter.sv]
// ---------------------------------------------------------------------------
// median_window_filter: streaming 2-d median filter
// Raster pixels in, per-channel window medians out, with reflected borders.
// ---------------------------------------------------------------------------
// Pixels (mode 0) arrive in raster order and are stored in a six-row line
// store; each output is the median of the (2r+1)x(2r+1) neighborhood, per
// channel, lagging the input by r rows and r columns. After the last pixel
// of a frame, drain words (mode 1) release the remaining outputs; the last
// one carries frame_end. For each output the back engine reads the n =
// (2r+1)^2 window pixels (1, 9 or 25) over the line store's single read
// port, lands the last read, sorts with odd-even transposition passes and
// loads the output register. A two-entry job queue and the output register
// let the input side run ahead. A new frame waits until the previous
// frame's jobs have left the store. Config writes restart the frame and
// must be made only while idle by the user; the block does not enforce it.
`default_nettype none

module median_window_filter import mwf_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cfg_we_i,
  input  wire logic [1:0]      cfg_idx_i,
  input  wire logic [CfgW-1:0] cfg_data_i,
  mwf_in_if.sink               in_ch,
  mwf_out_if.source            out_ch
);

  // raw register values
  logic [10:0] width_q;
  logic [12:0] height_q;
  logic [1:0]  radius_q;
  logic [2:0]  chcnt_q;
  cfg_t        cfg;

  job_t        fj, qj;
  wr_t         wr;
  logic        push, pop, q_full, q_empty, back_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd1024;
      height_q <= 13'd1024;
      radius_q <= 2'd1;
      chcnt_q  <= 3'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgWidth:    width_q  <= cfg_data_i[10:0];
        CfgHeight:   height_q <= cfg_data_i[12:0];
        CfgRadius:   radius_q <= cfg_data_i[1:0];
        CfgChannels: chcnt_q  <= cfg_data_i[2:0];
        default:     ;
      endcase
    end
  end

  // saturate to the supported ranges
  always_comb begin
    cfg.w  = (width_q < 11'd3) ? 11'd3 : (width_q > 11'(MaxWidth)) ? 11'(MaxWidth) : width_q;
    cfg.h  = (height_q < 13'd3) ? 13'd3 :
             (height_q > 13'(MaxHeight)) ? 13'(MaxHeight) : height_q;
    cfg.r  = (radius_q > 2'(MaxRadius)) ? 2'(MaxRadius) : radius_q;
    cfg.ch = (chcnt_q < 3'd1) ? 3'd1 : (chcnt_q > 3'(MaxChannels)) ? 3'(MaxChannels) : chcnt_q;
  end

  mwf_front u_front (
    .clk_i, .rst_ni,
    .cfg_i     (cfg),
    .restart_i (cfg_we_i),
    .busy_i    (back_busy || !q_empty),
    .q_full_i  (q_full),
    .in_ch     (in_ch),
    .push_o    (push),
    .job_o     (fj),
    .wr_o      (wr)
  );

  mwf_queue u_queue (
    .clk_i, .rst_ni,
    .push_i  (push),
    .job_i   (fj),
    .pop_i   (pop),
    .job_o   (qj),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  mwf_back u_back (
    .clk_i, .rst_ni,
    .cfg_i       (cfg),
    .wr_i        (wr),
    .job_i       (qj),
    .job_valid_i (!q_empty),
    .pop_o       (pop),
    .busy_o      (back_busy),
    .out_ch      (out_ch)
  );

  // no input word taken while the job queue has no room
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !in_ch.ready) else $error("word accepted with job queue full");

  // output columns stay inside the frame
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> ({1'b0, out_ch.out_x} < cfg.w)) else $error("output column out of frame");

  // frame end only on the last column
  a_end_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.frame_end) |-> ({1'b0, out_ch.out_x} == cfg.w - 11'd1))
    else $error("frame end away from last column");

endmodule

`default_nettype wire
